// ----- hw/rtl/drc_pkg.sv -----
// ----------------------------------------------------------------------------
// drc_pkg
// Shared constants, types and register codes of the damage rectangle
// coalescer.
// ----------------------------------------------------------------------------
package drc_pkg;

  localparam int MAX_TILES = 16;
  localparam int IDX_W     = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CNT_W     = $clog2(MAX_TILES + 1);
  localparam int CRD_W     = 15;
  localparam int BOX_W     = 4 * CRD_W;

  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;

  localparam logic [7:0] GROW_MARGIN_RST = 8'd30;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_AREA_LEFT   = 3'd0;
  localparam logic [2:0] REG_AREA_TOP    = 3'd1;
  localparam logic [2:0] REG_AREA_RIGHT  = 3'd2;
  localparam logic [2:0] REG_AREA_BOTTOM = 3'd3;
  localparam logic [2:0] REG_GROW_MARGIN = 3'd4;
  localparam logic [2:0] REG_CAPTURE_EN  = 3'd5;

  // Inclusive tile edges.
  typedef struct packed {
    logic [CRD_W-1:0] l;
    logic [CRD_W-1:0] t;
    logic [CRD_W-1:0] r;
    logic [CRD_W-1:0] b;
  } box_t;

  typedef struct packed {
    logic [CRD_W-1:0] area_left;
    logic [CRD_W-1:0] area_top;
    logic [CRD_W-1:0] area_right;
    logic [CRD_W-1:0] area_bottom;
    logic [7:0]       grow_margin;
    logic             capture_enable;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
  } in_t;

  typedef struct packed {
    logic [CRD_W-1:0] tile_x;
    logic [CRD_W-1:0] tile_y;
    logic [15:0]      tile_width;
    logic [15:0]      tile_height;
    logic             tile_valid;
    logic             last_tile;
    logic             store_overflowed;
  } tile_t;

  // Controller to datapath.
  typedef struct packed {
    logic             load_in;
    logic             clip;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_merge;
    logic             fl_clamp;
    logic             fl_fmt;
    logic             fl_empty;
    logic             last;
    logic             ovf;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic func;
    logic keep;
    logic hit;
  } sts_t;

endpackage

// ----- hw/rtl/drc_if.sv -----
// ----------------------------------------------------------------------------
// drc_in_if / drc_out_if
// Valid/ready channels carrying damage requests and coalesced tiles.
// ----------------------------------------------------------------------------
interface drc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic [15:0] rect_width;
  logic [15:0] rect_height;

  modport source (output valid, func, rect_x, rect_y, rect_width, rect_height,
                  input ready);
  modport sink (input valid, func, rect_x, rect_y, rect_width, rect_height,
                output ready);
endinterface

interface drc_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] tile_x;
  logic [14:0] tile_y;
  logic [15:0] tile_width;
  logic [15:0] tile_height;
  logic        tile_valid;
  logic        last_tile;
  logic        store_overflowed;

  modport source (output valid, tile_x, tile_y, tile_width, tile_height, tile_valid,
                  last_tile, store_overflowed, input ready);
  modport sink (input valid, tile_x, tile_y, tile_width, tile_height, tile_valid,
                last_tile, store_overflowed, output ready);
endinterface

// ----- hw/rtl/drc_ram.sv -----
// ----------------------------------------------------------------------------
// drc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module drc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/drc_dp.sv -----
// ----------------------------------------------------------------------------
// drc_dp
// Datapath: request register, clipping, tile store, overlap test and merge,
// and flush formatting into the result register.
// ----------------------------------------------------------------------------
module drc_dp (
  input  logic          clk,
  input  drc_pkg::in_t  in_data,
  input  drc_pkg::cfg_t cfg,
  input  drc_pkg::cmd_t cmd,
  output drc_pkg::sts_t sts,
  output drc_pkg::tile_t tile
);
  import drc_pkg::*;

  in_t        in_r;
  box_t       rect_r;
  logic       keep_r;
  logic [CRD_W-1:0] cl_r, ct_r, cr_r, cb_r;
  tile_t      tile_r;

  logic [BOX_W-1:0] rdata_raw;
  logic [BOX_W-1:0] wdata_raw;
  box_t       rd;
  box_t       merged;

  logic signed [17:0] xl, xr, yt, yb, al, ar, at, ab;
  logic       keep_nxt;
  box_t       clip_nxt;

  logic signed [16:0] gl, gt;
  logic [15:0] gr, gb;
  logic [CRD_W-1:0] cl_nxt, ct_nxt, cr_nxt, cb_nxt;

  assign rd = box_t'(rdata_raw);

  // Clip of the incoming rectangle against the capture area.
  always_comb begin
    xl = {{2{in_r.rect_x[15]}}, in_r.rect_x};
    yt = {{2{in_r.rect_y[15]}}, in_r.rect_y};
    xr = xl + $signed({2'b00, in_r.rect_width}) - 18'sd1;
    yb = yt + $signed({2'b00, in_r.rect_height}) - 18'sd1;
    al = $signed({3'b000, cfg.area_left});
    ar = $signed({3'b000, cfg.area_right});
    at = $signed({3'b000, cfg.area_top});
    ab = $signed({3'b000, cfg.area_bottom});
    keep_nxt = (in_r.rect_width != '0) && (in_r.rect_height != '0) &&
               (ar >= al) && (ab >= at) &&
               (xl <= ar) && (al <= xr) && (yt <= ab) && (at <= yb);
    clip_nxt.l = (xl > al) ? xl[CRD_W-1:0] : cfg.area_left;
    clip_nxt.t = (yt > at) ? yt[CRD_W-1:0] : cfg.area_top;
    clip_nxt.r = (xr < ar) ? xr[CRD_W-1:0] : cfg.area_right;
    clip_nxt.b = (yb < ab) ? yb[CRD_W-1:0] : cfg.area_bottom;
  end

  // Overlap of the clipped rectangle with the tile just read, and their union.
  always_comb begin
    sts.func = in_r.func;
    sts.keep = keep_r;
    sts.hit  = (rect_r.l <= rd.r) && (rd.l <= rect_r.r) &&
               (rect_r.t <= rd.b) && (rd.t <= rect_r.b);
    merged.l = (rd.l < rect_r.l) ? rd.l : rect_r.l;
    merged.t = (rd.t < rect_r.t) ? rd.t : rect_r.t;
    merged.r = (rd.r > rect_r.r) ? rd.r : rect_r.r;
    merged.b = (rd.b > rect_r.b) ? rd.b : rect_r.b;
    wdata_raw = cmd.wr_merge ? merged : rect_r;
  end

  // Flush: grow by the margin and clamp to the area. Results stay in range.
  always_comb begin
    gl = $signed({2'b00, rd.l}) - $signed({9'b0, cfg.grow_margin});
    gt = $signed({2'b00, rd.t}) - $signed({9'b0, cfg.grow_margin});
    gr = {1'b0, rd.r} + {8'b0, cfg.grow_margin};
    gb = {1'b0, rd.b} + {8'b0, cfg.grow_margin};
    cl_nxt = (gl > $signed({2'b00, cfg.area_left})) ? gl[CRD_W-1:0] : cfg.area_left;
    ct_nxt = (gt > $signed({2'b00, cfg.area_top}))  ? gt[CRD_W-1:0] : cfg.area_top;
    cr_nxt = (gr < {1'b0, cfg.area_right})  ? gr[CRD_W-1:0] : cfg.area_right;
    cb_nxt = (gb < {1'b0, cfg.area_bottom}) ? gb[CRD_W-1:0] : cfg.area_bottom;
  end

  drc_ram #(
    .WIDTH (BOX_W),
    .DEPTH (MAX_TILES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (cmd.wr_addr),
    .wdata (wdata_raw),
    .raddr (cmd.rd_addr),
    .rdata (rdata_raw)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.clip) begin
      rect_r <= clip_nxt;
      keep_r <= keep_nxt;
    end
    if (cmd.fl_clamp) begin
      cl_r <= cl_nxt;
      ct_r <= ct_nxt;
      cr_r <= cr_nxt;
      cb_r <= cb_nxt;
    end
    if (cmd.fl_fmt) begin
      tile_r.tile_x      <= cl_r - cfg.area_left;
      tile_r.tile_y      <= ct_r - cfg.area_top;
      tile_r.tile_width  <= (cr_r >= cl_r) ? ({1'b0, cr_r} - {1'b0, cl_r} + 16'd1) : 16'd0;
      tile_r.tile_height <= (cb_r >= ct_r) ? ({1'b0, cb_r} - {1'b0, ct_r} + 16'd1) : 16'd0;
      tile_r.tile_valid  <= 1'b1;
      tile_r.last_tile   <= cmd.last;
      tile_r.store_overflowed <= cmd.ovf;
    end else if (cmd.fl_empty) begin
      tile_r.tile_x      <= '0;
      tile_r.tile_y      <= '0;
      tile_r.tile_width  <= '0;
      tile_r.tile_height <= '0;
      tile_r.tile_valid  <= 1'b0;
      tile_r.last_tile   <= 1'b1;
      tile_r.store_overflowed <= cmd.ovf;
    end
  end

  assign tile = tile_r;

endmodule

// ----- hw/rtl/drc_ctrl.sv -----
// ----------------------------------------------------------------------------
// drc_ctrl
// Controller: sequences clipping, the in-order scan of the tile store, and
// the flush walk; owns the tile count, the overflow flag and the handshakes.
// ----------------------------------------------------------------------------
module drc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  drc_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  drc_pkg::sts_t sts,
  output drc_pkg::cmd_t cmd
);
  import drc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_START,
    ST_SCAN,
    ST_FL_RD,
    ST_FL_CLAMP,
    ST_FL_FMT,
    ST_FL_OUT,
    ST_EMPTY_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] last_idx;
  logic             is_last;

  assign last_idx  = count_r - CNT_W'(1);
  assign is_last   = (rd_idx_r == last_idx);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    chk_idx_nxt   = chk_idx_r;
    chk_vld_nxt   = 1'b0;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;

    cmd          = '0;
    cmd.rd_addr  = rd_idx_r[IDX_W-1:0];
    cmd.ovf      = ovf_r;
    cmd.last     = is_last;

    case (state_r)
      ST_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.clip = 1'b1;
        if (sts.func) begin
          if (!cfg.capture_enable || (count_r == '0)) begin
            cmd.fl_empty  = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_EMPTY_OUT;
          end else begin
            rd_idx_nxt = '0;
            state_nxt  = ST_FL_RD;
          end
        end else begin
          state_nxt = ST_SCAN_START;
        end
      end
      ST_SCAN_START: begin
        if (!sts.keep) begin
          state_nxt = ST_IDLE;
        end else if (count_r == '0) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = '0;
          count_nxt   = CNT_W'(1);
          state_nxt   = ST_IDLE;
        end else begin
          rd_idx_nxt = '0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Reads are issued one ahead of the compare on the returned tile.
        if (rd_idx_r < count_r) begin
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_idx_r[IDX_W-1:0];
        end
        if (chk_vld_r) begin
          if (sts.hit) begin
            cmd.wr_en    = 1'b1;
            cmd.wr_addr  = chk_idx_r;
            cmd.wr_merge = 1'b1;
            state_nxt    = ST_IDLE;
          end else if (chk_idx_r == last_idx[IDX_W-1:0]) begin
            cmd.wr_en = 1'b1;
            if (count_r < CNT_W'(MAX_TILES)) begin
              cmd.wr_addr = count_r[IDX_W-1:0];
              count_nxt   = count_r + CNT_W'(1);
            end else begin
              // Store full: the tile just read is the last one, merge into it.
              cmd.wr_addr  = IDX_W'(MAX_TILES - 1);
              cmd.wr_merge = 1'b1;
              ovf_nxt      = 1'b1;
            end
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FL_RD: begin
        state_nxt = ST_FL_CLAMP;
      end
      ST_FL_CLAMP: begin
        cmd.fl_clamp = 1'b1;
        state_nxt    = ST_FL_FMT;
      end
      ST_FL_FMT: begin
        cmd.fl_fmt    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_FL_OUT;
      end
      ST_FL_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (is_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + CNT_W'(1);
            state_nxt  = ST_FL_RD;
          end
        end
      end
      ST_EMPTY_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (cfg.capture_enable) begin
            ovf_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      chk_idx_r   <= '0;
      chk_vld_r   <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      chk_idx_r   <= chk_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/damage_rect_coalescer_core.sv -----
// ----------------------------------------------------------------------------
// damage_rect_coalescer_core
// Coalesces screen damage rectangles into a small tile store and hands the
// grown, clamped tiles out on a flush.
//
//   Channel  Direction  Handshake                   Carries
//   in_ch    in         valid/ready                 func, rect_x/y, width/height
//   out_ch   out        valid/ready                 one tile or empty result
//   APB      in         psel/penable/pwrite/pready  capture area, margin, enable
//
// An add compares the clipped rectangle with the stored tiles in turn: the store
// is a one-read-port RAM scanned one tile per cycle. A dropped rectangle or one
// going into an empty store skips the scan. A flush passes a decode state, then
// reads, clamps, formats and hands out each tile, waiting as long as the sink
// stalls; the tile store RAM and a single result register set these steps.
// One item is worked on at a time. Reset is synchronous and needs no clearing
// pass: only tiles below the count are ever read.
// ----------------------------------------------------------------------------
module damage_rect_coalescer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  drc_in_if.sink                        in_ch,
  drc_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [drc_pkg::APB_AW-1:0]    paddr,
  input  logic [drc_pkg::APB_DW-1:0]    pwdata,
  output logic [drc_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import drc_pkg::*;

  cfg_t       cfg_r;
  in_t        in_data;
  cmd_t       cmd;
  sts_t       sts;
  tile_t      tile;
  logic [2:0] reg_idx;
  logic       wr_xfer;

  assign reg_idx = paddr[4:2];
  assign wr_xfer = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.area_left      <= '0;
      cfg_r.area_top       <= '0;
      cfg_r.area_right     <= '0;
      cfg_r.area_bottom    <= '0;
      cfg_r.grow_margin    <= GROW_MARGIN_RST;
      cfg_r.capture_enable <= 1'b0;
    end else if (wr_xfer) begin
      case (reg_idx)
        REG_AREA_LEFT:   cfg_r.area_left      <= pwdata[CRD_W-1:0];
        REG_AREA_TOP:    cfg_r.area_top       <= pwdata[CRD_W-1:0];
        REG_AREA_RIGHT:  cfg_r.area_right     <= pwdata[CRD_W-1:0];
        REG_AREA_BOTTOM: cfg_r.area_bottom    <= pwdata[CRD_W-1:0];
        REG_GROW_MARGIN: cfg_r.grow_margin    <= pwdata[7:0];
        REG_CAPTURE_EN:  cfg_r.capture_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_AREA_LEFT:   prdata = APB_DW'(cfg_r.area_left);
      REG_AREA_TOP:    prdata = APB_DW'(cfg_r.area_top);
      REG_AREA_RIGHT:  prdata = APB_DW'(cfg_r.area_right);
      REG_AREA_BOTTOM: prdata = APB_DW'(cfg_r.area_bottom);
      REG_GROW_MARGIN: prdata = APB_DW'(cfg_r.grow_margin);
      REG_CAPTURE_EN:  prdata = APB_DW'(cfg_r.capture_enable);
      default:         prdata = '0;
    endcase
  end

  assign in_data.func        = in_ch.func;
  assign in_data.rect_x      = in_ch.rect_x;
  assign in_data.rect_y      = in_ch.rect_y;
  assign in_data.rect_width  = in_ch.rect_width;
  assign in_data.rect_height = in_ch.rect_height;

  drc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  drc_dp u_dp (
    .clk     (clk),
    .in_data (in_data),
    .cfg     (cfg_r),
    .cmd     (cmd),
    .sts     (sts),
    .tile    (tile)
  );

  assign out_ch.tile_x           = tile.tile_x;
  assign out_ch.tile_y           = tile.tile_y;
  assign out_ch.tile_width       = tile.tile_width;
  assign out_ch.tile_height      = tile.tile_height;
  assign out_ch.tile_valid       = tile.tile_valid;
  assign out_ch.last_tile        = tile.last_tile;
  assign out_ch.store_overflowed = tile.store_overflowed;

endmodule
